@@ hdl/bbe_pkg.sv @@
// Package for the Bubble Babble encoder: beat descriptor type, character
// tables and the small constant-divisor helpers. No dependencies.
package bbe_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned NumSlots   = 8;

  // Character slot positions inside one descriptor, in output order
  localparam logic [2:0] SlotOpen  = 3'd0;
  localparam logic [2:0] SlotBody0 = 3'd1;
  localparam logic [2:0] SlotBody1 = 3'd2;
  localparam logic [2:0] SlotBody2 = 3'd3;
  localparam logic [2:0] SlotTail0 = 3'd4;
  localparam logic [2:0] SlotTailX = 3'd5;
  localparam logic [2:0] SlotTail2 = 3'd6;
  localparam logic [2:0] SlotClose = 3'd7;

  localparam logic [7:0] CharX    = 8'h78;
  localparam logic [7:0] CharDash = 8'h2D;

  localparam logic [4:0] ConsX = 5'd16;

  // floor(x/36) = (x*Recip36) >> 16, exact for x < 2216
  localparam logic [22:0] Recip36 = 23'd1821;
  // floor(v/6) = (v*Recip6) >> 8, exact for v < 64
  localparam logic [11:0] Recip6  = 12'd43;

  // One accepted beat turned into up to seven characters
  typedef struct packed {
    logic [NumSlots-1:0] mask;   // slot enables
    logic [2:0][7:0]     body;   // body characters, body[0] first
    logic [5:0]          seed;   // seed for the closing tail
  } bbe_desc_t;

  function automatic logic [7:0] vowel(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h61; // a
      3'd1:    c = 8'h65; // e
      3'd2:    c = 8'h69; // i
      3'd3:    c = 8'h6F; // o
      3'd4:    c = 8'h75; // u
      3'd5:    c = 8'h79; // y
      default: c = 8'h61;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] consonant(input logic [4:0] idx);
    logic [7:0] c;
    unique case (idx)
      5'd0:    c = 8'h62; // b
      5'd1:    c = 8'h63; // c
      5'd2:    c = 8'h64; // d
      5'd3:    c = 8'h66; // f
      5'd4:    c = 8'h67; // g
      5'd5:    c = 8'h68; // h
      5'd6:    c = 8'h6B; // k
      5'd7:    c = 8'h6C; // l
      5'd8:    c = 8'h6D; // m
      5'd9:    c = 8'h6E; // n
      5'd10:   c = 8'h70; // p
      5'd11:   c = 8'h72; // r
      5'd12:   c = 8'h73; // s
      5'd13:   c = 8'h74; // t
      5'd14:   c = 8'h76; // v
      5'd15:   c = 8'h7A; // z
      5'd16:   c = 8'h78; // x
      default: c = 8'h78;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] div6(input logic [5:0] v);
    logic [11:0] p;
    p = 12'(v) * Recip6;
    return p[11:8];
  endfunction

  function automatic logic [2:0] mod6(input logic [5:0] v);
    logic [3:0] q;
    logic [5:0] r;
    q = div6(v);
    r = v - 6'(q) * 6'd6;
    return r[2:0];
  endfunction

  function automatic logic [5:0] mod36(input logic [11:0] x);
    logic [22:0] p;
    logic [5:0]  q;
    logic [11:0] r;
    p = 23'(x) * Recip36;
    q = p[21:16];
    r = x - 12'(q) * 12'd36;
    return r[5:0];
  endfunction

endpackage

@@ hdl/bbe_front.sv @@
// Front end: accepts message beats, tracks pair/seed state and emits one
// character descriptor per beat. Depends on bbe_pkg.
module bbe_front import bbe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_eom_i,
  input  logic       in_empty_i,
  input  logic       q_full_i,
  output logic       in_ready_o,
  output logic       push_o,
  output bbe_desc_t  desc_o
);

  logic [5:0] seed_q, seed_d;
  logic [7:0] held_q, held_d;
  logic       await_q, await_d;
  logic       start_q, start_d;

  logic        accept;
  logic        await_eff;
  logic [5:0]  seed_eff;
  logic [5:0]  v0_sum;
  logic [3:0]  v2_sum;
  logic [3:0]  seed_div;
  logic [11:0] mix;
  logic [5:0]  seed_new;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  always_comb begin
    await_eff = start_q ? 1'b0 : await_q;
    seed_eff  = start_q ? 6'd1 : seed_q;
    seed_div  = div6(seed_eff);
    v0_sum    = 6'(in_byte_i[7:6]) + seed_eff;
    v2_sum    = 4'(in_byte_i[1:0]) + seed_div;
    if (v2_sum >= 4'd6) begin
      v2_sum = v2_sum - 4'd6;
    end
    mix      = 12'(seed_eff) * 12'd5 + 12'(held_q) * 12'd7 + 12'(in_byte_i);
    seed_new = mod36(mix);

    desc_o            = '0;
    desc_o.mask[SlotOpen] = start_q;
    desc_o.seed       = seed_eff;
    seed_d  = seed_eff;
    held_d  = held_q;
    await_d = await_eff;
    start_d = 1'b0;

    if (in_empty_i) begin
      desc_o.mask[SlotTail0] = !await_eff;
      desc_o.mask[SlotTailX] = !await_eff;
      desc_o.mask[SlotTail2] = !await_eff;
      desc_o.mask[SlotClose] = 1'b1;
    end else if (!await_eff) begin
      desc_o.mask[SlotBody0] = 1'b1;
      desc_o.mask[SlotBody1] = 1'b1;
      desc_o.mask[SlotBody2] = 1'b1;
      desc_o.body[0] = vowel(mod6(v0_sum));
      desc_o.body[1] = consonant({1'b0, in_byte_i[5:2]});
      desc_o.body[2] = vowel(v2_sum[2:0]);
      held_d  = in_byte_i;
      await_d = 1'b1;
      // odd length: close with a bare 'x'
      desc_o.mask[SlotClose] = in_eom_i;
    end else begin
      desc_o.mask[SlotBody0] = 1'b1;
      desc_o.mask[SlotBody1] = 1'b1;
      desc_o.mask[SlotBody2] = 1'b1;
      desc_o.body[0] = consonant({1'b0, in_byte_i[7:4]});
      desc_o.body[1] = CharDash;
      desc_o.body[2] = consonant({1'b0, in_byte_i[3:0]});
      desc_o.seed    = seed_new;
      seed_d  = seed_new;
      await_d = 1'b0;
      desc_o.mask[SlotTail0] = in_eom_i;
      desc_o.mask[SlotTailX] = in_eom_i;
      desc_o.mask[SlotTail2] = in_eom_i;
      desc_o.mask[SlotClose] = in_eom_i;
    end

    // message done: back to the idle state
    if (in_empty_i || in_eom_i) begin
      seed_d  = 6'd1;
      held_d  = '0;
      await_d = 1'b0;
      start_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= 6'd1;
      held_q  <= '0;
      await_q <= 1'b0;
      start_q <= 1'b1;
    end else if (accept) begin
      seed_q  <= seed_d;
      held_q  <= held_d;
      await_q <= await_d;
      start_q <= start_d;
    end
  end

endmodule

@@ hdl/bbe_queue.sv @@
// Short descriptor queue between front and back end.
// Depends on bbe_pkg.
module bbe_queue import bbe_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  bbe_desc_t push_data_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      valid_o,
  output bbe_desc_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bbe_desc_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= bump(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= bump(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ hdl/bbe_back.sv @@
// Back end: walks the enabled slots of the head descriptor and drives one
// character per beat through an output register. Depends on bbe_pkg.
module bbe_back import bbe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  bbe_desc_t head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic [7:0] out_char_o,
  output logic      out_last_o
);

  logic [NumSlots-1:0] done_q, done_d;
  logic [NumSlots-1:0] pend, sel_hot;
  logic [2:0]          sel;
  logic                load;
  logic [7:0]          chr;
  logic [2:0]          tail_lo;
  logic [3:0]          tail_hi;

  logic                valid_q;
  logic [7:0]          char_q;
  logic                last_q;

  always_comb begin
    tail_lo = mod6(head_i.seed);
    tail_hi = div6(head_i.seed);
    pend    = head_i.mask & ~done_q;
    sel     = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel = 3'(i);
      end
    end
    sel_hot = NumSlots'(1) << sel;

    unique case (sel)
      SlotOpen:  chr = CharX;
      SlotBody0: chr = head_i.body[0];
      SlotBody1: chr = head_i.body[1];
      SlotBody2: chr = head_i.body[2];
      SlotTail0: chr = vowel(tail_lo);
      SlotTailX: chr = consonant(ConsX);
      SlotTail2: chr = vowel(tail_hi[2:0]);
      SlotClose: chr = CharX;
      default:   chr = CharX;
    endcase

    load   = q_valid_i && (!valid_q || out_ready_i);
    pop_o  = load && ((pend & ~sel_hot) == '0);
    done_d = done_q;
    if (load) begin
      done_d = pop_o ? '0 : (done_q | sel_hot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= chr;
      last_q <= (sel == SlotClose);
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

endmodule

@@ hdl/bubble_babble_encoder_core.sv @@
// Top level of the streaming Bubble Babble encoder.
// Depends on bbe_pkg, bbe_front, bbe_queue and bbe_back.

// Bubble Babble encoder. Message bytes enter one per beat on the slave side
// (tlast marks the final byte, tuser marks an empty message whose tdata is
// ignored); ASCII characters leave one per beat on the master side, with tlast
// on the closing 'x' of each message. A message opens with 'x', each byte pair
// gives vowel-consonant-vowel and consonant-dash-consonant, and an even-length
// message (zero included) ends with a vowel-'x'-vowel tail before the closing
// 'x'. The front end turns each input beat into a descriptor of up to seven
// characters in the cycle it is accepted; a 2-entry descriptor queue
// decouples it from the back end, which sends one character per cycle through
// a registered output while the master side is ready. Sustained throughput is
// therefore bounded by the output port: one character per cycle, with three
// characters per byte in a long message and up to seven for a closing beat.
// With the back end idle, the first character of a beat passes through the
// queue entry and then the output register before it shows on the master side.
module bubble_babble_encoder_core import bbe_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // end_of_message
  input  logic       s_axis_tuser_i,   // [0] empty_message
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_char
  output logic       m_axis_tlast_o    // last_char
);

  bbe_desc_t push_desc, head_desc;
  logic      push, pop, q_full, q_valid;

  // Front: pair tracking, seed update, per-beat character descriptor
  bbe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_byte_i  (s_axis_tdata_i),
    .in_eom_i   (s_axis_tlast_i),
    .in_empty_i (s_axis_tuser_i),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready_o),
    .push_o     (push),
    .desc_o     (push_desc)
  );

  // Descriptor queue
  bbe_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (head_desc)
  );

  // Back: character serializer with output register
  bbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (head_desc),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

@@ tb/bubble_babble_encoder_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for bubble_babble_encoder_core: directed table, then random
// messages, checked against typed-in text or an in-bench predictor. Needs bbe_pkg.
module bubble_babble_encoder_core_tb import bbe_pkg::*; ();

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned PhaseItems = 60;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_t;

  // Directed row: one input beat; spelled holds the typed-in characters, or is
  // empty when the predictor supplies them
  typedef struct {
    logic [7:0] data;
    logic       eom;
    logic       empty;
    string      spelled;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       s_tuser = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  string vowel_set = "aeiouy";
  string cons_set  = "bcdfghklmnprstvzx";

  // Predictor state
  int unsigned bb_seed = 1;
  int unsigned pair_first = 0;
  bit          second_due = 1'b0;
  bit          open_pending = 1'b1;

  char_t       expected_chars[$];
  int unsigned err_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          rx_hold_req = 1'b0;

  dir_row_t dir_rows[19] = '{
    '{8'h00, 1'b0, 1'b1, "xexax"},  // empty message right after reset
    '{8'h00, 1'b1, 1'b0, "xebax"},  // one byte, all zeros
    '{8'hFF, 1'b1, 1'b0, "xuzox"},  // one byte, all ones
    '{8'hFF, 1'b1, 1'b1, "xexax"},  // empty: data and tlast ignored
    '{8'h00, 1'b0, 1'b0, ""},       // two bytes -> even tail
    '{8'hFF, 1'b1, 1'b0, ""},
    '{8'hFF, 1'b0, 1'b0, ""},       // three bytes
    '{8'h00, 1'b0, 1'b0, ""},
    '{8'h55, 1'b1, 1'b0, ""},
    '{8'hA5, 1'b0, 1'b0, ""},       // empty ends a message of odd length
    '{8'h00, 1'b0, 1'b1, ""},
    '{8'h3C, 1'b0, 1'b0, ""},       // empty ends a message of even length
    '{8'hC3, 1'b0, 1'b0, ""},
    '{8'h5A, 1'b0, 1'b1, ""},
    '{8'h12, 1'b0, 1'b0, ""},       // four bytes, seed carried across pairs
    '{8'h34, 1'b0, 1'b0, ""},
    '{8'h56, 1'b0, 1'b0, ""},
    '{8'h78, 1'b1, 1'b0, ""},
    '{8'hAA, 1'b1, 1'b0, ""}        // state back at reset values
  };

  bubble_babble_encoder_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [7:0] data_byte
    .s_axis_tlast_i  (s_tlast),   // end_of_message
    .s_axis_tuser_i  (s_tuser),   // [0] empty_message
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [7:0] out_char
    .m_axis_tlast_o  (m_tlast)    // last_char
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("bubble_babble_encoder_core: mismatch");
      $finish;
    end
  end

  function automatic char_t mk_char(input byte unsigned c, input bit last);
    char_t r;
    r.ch   = c;
    r.last = last;
    return r;
  endfunction

  // Characters one input beat completes; updates the predictor state
  task automatic encode_beat(input logic [7:0] b, input logic eom, input logic empty,
                             output char_t chars[$]);
    int unsigned bv;
    bv = int'(b);
    chars = {};
    if (open_pending) begin
      chars.push_back(mk_char(CharX, 1'b0));
      open_pending = 1'b0;
      bb_seed = 1;
      second_due = 1'b0;
    end
    if (!empty) begin
      if (!second_due) begin
        chars.push_back(mk_char(vowel_set[((bv >> 6) + bb_seed) % 6], 1'b0));
        chars.push_back(mk_char(cons_set[(bv >> 2) & 15], 1'b0));
        chars.push_back(mk_char(vowel_set[((bv & 3) + bb_seed / 6) % 6], 1'b0));
        pair_first = bv;
        second_due = 1'b1;
      end else begin
        chars.push_back(mk_char(cons_set[(bv >> 4) & 15], 1'b0));
        chars.push_back(mk_char(CharDash, 1'b0));
        chars.push_back(mk_char(cons_set[bv & 15], 1'b0));
        bb_seed = (bb_seed * 5 + pair_first * 7 + bv) % 36;
        second_due = 1'b0;
      end
    end
    if (empty || eom) begin
      // even count (zero too): vowel-x-vowel tail before the closing x
      if (!second_due) begin
        chars.push_back(mk_char(vowel_set[bb_seed % 6], 1'b0));
        chars.push_back(mk_char(CharX, 1'b0));
        chars.push_back(mk_char(vowel_set[(bb_seed / 6) % 6], 1'b0));
      end
      chars.push_back(mk_char(CharX, 1'b1));
      bb_seed = 1;
      pair_first = 0;
      second_due = 1'b0;
      open_pending = 1'b1;
    end
  endtask

  // Offer one beat (after random idle cycles), wait for it to be taken,
  // then queue the characters it should produce
  task automatic send_beat(input logic [7:0] b, input logic eom, input logic empty,
                           input string spelled);
    char_t chars[$];
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eom;
    s_tuser  <= empty;
    do @(posedge clk_i); while (!s_tready);
    items_sent++;
    encode_beat(b, eom, empty, chars);
    if (spelled.len() != 0) begin
      chars = {};
      for (int i = 0; i < spelled.len(); i++)
        chars.push_back(mk_char(spelled[i], i == spelled.len() - 1));
    end
    foreach (chars[i]) expected_chars.push_back(chars[i]);
  endtask

  // One random message: mostly short, a few long; some end on an empty beat,
  // some are empty messages on their own
  task automatic send_message();
    int unsigned len;
    bit          via_empty;
    if ($urandom_range(99) < 10) len = 0;
    else if ($urandom_range(99) < 6) len = $urandom_range(40, 20);
    else len = $urandom_range(8, 1);
    via_empty = (len == 0) || ($urandom_range(99) < 20);
    for (int unsigned i = 0; i < len; i++)
      send_beat(8'($urandom), (i == len - 1) && !via_empty, 1'b0, "");
    if (via_empty) send_beat(8'($urandom), 1'($urandom), 1'b1, "");
  endtask

  // Sender goes quiet until every queued character has come out
  task automatic pause_until_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_chars.size() != 0);
  endtask

  // Receiver: random backpressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Output check against the oldest expected character
  always @(posedge clk_i) begin
    char_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_chars.size() == 0) begin
        $error("out_char %h arrived with nothing expected", m_tdata);
        err_count++;
      end else begin
        want = expected_chars.pop_front();
        if (m_tdata !== want.ch) begin
          $error("out_char expected %h actual %h", want.ch, m_tdata);
          err_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last_char expected %b actual %b", want.last, m_tlast);
          err_count++;
        end
      end
    end
  end

  initial begin
    int unsigned target;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender light idle, receiver heavy idle
    tx_idle_pct = 14;
    rx_idle_pct = 82;
    foreach (dir_rows[i])
      send_beat(dir_rows[i].data, dir_rows[i].eom, dir_rows[i].empty, dir_rows[i].spelled);
    target = items_sent + PhaseItems;
    while (items_sent < target) send_message();
    pause_until_drained();

    // sender heavy idle, receiver light idle
    tx_idle_pct = 82;
    rx_idle_pct = 14;
    target = items_sent + PhaseItems;
    while (items_sent < target) send_message();
    pause_until_drained();

    // no idling; receiver first holds off long enough to back up the input
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = 1'b1;
    target = items_sent + PhaseItems;
    while (items_sent < target) send_message();
    pause_until_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0 && expected_chars.size() == 0) begin
      $display("bubble_babble_encoder_core: match");
    end else begin
      $display("bubble_babble_encoder_core: mismatch");
    end
    $finish;
  end

endmodule
